>>> hdl/directory_entry_lookup_defines.svh
// ----------------------------------------------------------------------------
// directory_entry_lookup_defines.svh
// Assertion macros for the directory entry lookup block.
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_LOOKUP_DEFINES_SVH
`define DIRECTORY_ENTRY_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every rising clk edge outside reset
`define DLK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that a condition never holds
`define DLK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DLK_ASSERT(label, prop, msg)
`define DLK_NEVER(label, cond, msg)
`endif

`endif

>>> hdl/dlk_pkg.sv
// ----------------------------------------------------------------------------
// dlk_pkg
// Shared widths, codes and the broadcast control bundle of the lookup chain.
// ----------------------------------------------------------------------------
package dlk_pkg;

	localparam int KIND_W   = 2;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int WORD_W   = 64;
	localparam int TYPE_W   = 8;
	localparam int INODE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int NAME_MAX_W = 4 * WORD_W;

	localparam int DEF_ENTRIES    = 64;
	localparam int DEF_NAME_BYTES = 32;

	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             flush;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		logic             rd_mode;
		logic [IDX_W-1:0] rd_idx;
	} dlk_ctrl_t;

endpackage

>>> hdl/directory_entry_lookup.sv
// ----------------------------------------------------------------------------
// directory_entry_lookup
// Directory table of fixed-length names: load, lookup by name, read by index.
// ----------------------------------------------------------------------------
//  channel   signals                                 handshake
//  command   kind, entry_index, name_word0..3,       start, taken when !busy
//            file_type, inode_number
//  result    status, found_index, out_word0..3,      done, one cycle, no stall
//            out_type, out_inode
//  config    cfg_wdata (entry_count)                 cfg_we
//
// A load, an unused kind, a read out of range or a lookup with an empty table
// answers on the cycle after start. A lookup or read sends a token down the
// chain of cells, one cell per cycle; a hit is trimmed and returned, busy
// high until then, and a miss answers at the last counted entry. Reset
// clears the sequencer, tokens and entry_count; entry contents are undefined
// until loaded. The result port never stalls.
`include "directory_entry_lookup_defines.svh"

module directory_entry_lookup #(
	parameter int ENTRIES    = dlk_pkg::DEF_ENTRIES,
	parameter int NAME_BYTES = dlk_pkg::DEF_NAME_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dlk_pkg::KIND_W-1:0]     kind,
	input  logic [dlk_pkg::IDX_W-1:0]      entry_index,
	input  logic [dlk_pkg::WORD_W-1:0]     name_word0,
	input  logic [dlk_pkg::WORD_W-1:0]     name_word1,
	input  logic [dlk_pkg::WORD_W-1:0]     name_word2,
	input  logic [dlk_pkg::WORD_W-1:0]     name_word3,
	input  logic [dlk_pkg::TYPE_W-1:0]     file_type,
	input  logic [dlk_pkg::INODE_W-1:0]    inode_number,
	input  logic                           cfg_we,
	input  logic [dlk_pkg::CNT_W-1:0]      cfg_wdata,
	output logic                           done,
	output logic [dlk_pkg::STATUS_W-1:0]   status,
	output logic [dlk_pkg::IDX_W-1:0]      found_index,
	output logic [dlk_pkg::WORD_W-1:0]     out_word0,
	output logic [dlk_pkg::WORD_W-1:0]     out_word1,
	output logic [dlk_pkg::WORD_W-1:0]     out_word2,
	output logic [dlk_pkg::WORD_W-1:0]     out_word3,
	output logic [dlk_pkg::TYPE_W-1:0]     out_type,
	output logic [dlk_pkg::INODE_W-1:0]    out_inode
);
	import dlk_pkg::*;

	localparam int NAME_W = NAME_BYTES * 8;
	localparam int POS_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LIM_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (LIM_W > CNT_W) ? LIM_W : CNT_W;
	localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CUT} state_t;

	// byte j is compared when all bytes before it are nonzero
	function automatic logic [NAME_W-1:0] care_mask(input logic [NAME_W-1:0] nm);
		logic [NAME_BYTES-1:0] nz;
		logic [NAME_BYTES-1:0] low;
		logic [NAME_W-1:0]     m;
		int                    j;
		for (j = 0; j < NAME_BYTES; j++) begin
			nz[j] = |nm[8*j +: 8];
		end
		for (j = 0; j < NAME_BYTES; j++) begin
			low = {NAME_BYTES{1'b1}} >> (NAME_BYTES - j);
			m[8*j +: 8] = {8{(nz & low) == low}};
		end
		return m;
	endfunction

	// byte j survives when bytes 0..j are all nonzero
	function automatic logic [NAME_W-1:0] keep_mask(input logic [NAME_W-1:0] nm);
		logic [NAME_BYTES-1:0] nz;
		logic [NAME_BYTES-1:0] low;
		logic [NAME_W-1:0]     m;
		int                    j;
		for (j = 0; j < NAME_BYTES; j++) begin
			nz[j] = |nm[8*j +: 8];
		end
		for (j = 0; j < NAME_BYTES; j++) begin
			low = {NAME_BYTES{1'b1}} >> (NAME_BYTES - 1 - j);
			m[8*j +: 8] = {8{(nz & low) == low}};
		end
		return m;
	endfunction

	state_t                state_q;
	logic [CNT_W-1:0]      entry_count_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      last_q;
	logic                  rd_mode_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [NAME_W-1:0]     query_q;
	logic [NAME_W-1:0]     care_q;
	logic [NAME_W-1:0]     raw_name_q;
	logic [TYPE_W-1:0]     raw_type_q;
	logic [INODE_W-1:0]    raw_inode_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IDX_W-1:0]      found_q;
	logic [NAME_MAX_W-1:0] out_name_q;
	logic [TYPE_W-1:0]     out_type_q;
	logic [INODE_W-1:0]    out_inode_q;

	logic [NAME_MAX_W-1:0] in_name;
	logic [NAME_W-1:0]     wr_name;
	logic                  accept;
	logic [CMP_W-1:0]      cnt_ext;
	logic [CMP_W-1:0]      act_cnt;
	logic [CMP_W-1:0]      idx_ext;
	logic                  launch;
	logic                  at_last;
	logic                  any_sel;
	dlk_ctrl_t             ctrl;

	logic [ENTRIES:0]      tok;
	logic [ENTRIES-1:0]    cell_sel;
	logic [NAME_W-1:0]     cell_name  [ENTRIES];
	logic [TYPE_W-1:0]     cell_type  [ENTRIES];
	logic [INODE_W-1:0]    cell_inode [ENTRIES];
	logic [NAME_W-1:0]     pick_name;
	logic [TYPE_W-1:0]     pick_type;
	logic [INODE_W-1:0]    pick_inode;

	assign in_name = {name_word3, name_word2, name_word1, name_word0};
	assign wr_name = in_name[NAME_W-1:0];
	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);

	assign cnt_ext = CMP_W'(entry_count_q);
	assign act_cnt = (cnt_ext > ENT_C) ? ENT_C : cnt_ext;
	assign idx_ext = CMP_W'(entry_index);

	assign launch = accept && (((kind == KIND_LOOKUP) && (act_cnt != '0)) ||
		((kind == KIND_READ) && (idx_ext < act_cnt)));

	assign any_sel = |cell_sel;
	assign at_last = (pos_q == last_q);

	always_comb begin
		ctrl.flush   = (state_q == ST_SCAN) && (any_sel || at_last);
		ctrl.wr_en   = accept && (kind == KIND_LOAD) && (idx_ext < ENT_C);
		ctrl.wr_idx  = entry_index;
		ctrl.rd_mode = rd_mode_q;
		ctrl.rd_idx  = rd_idx_q;
	end

	assign tok[0] = launch;

	for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
		dlk_cell #(
			.CELL_IDX  (e),
			.NAME_BYTES(NAME_BYTES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.wr_name  (wr_name),
			.wr_type  (file_type),
			.wr_inode (inode_number),
			.query    (query_q),
			.care     (care_q),
			.tok_in   (tok[e]),
			.tok_out  (tok[e+1]),
			.sel      (cell_sel[e]),
			.sel_name (cell_name[e]),
			.sel_type (cell_type[e]),
			.sel_inode(cell_inode[e])
		);
	end

	// at most one cell selects, so an OR picks its entry
	always_comb begin
		pick_name  = '0;
		pick_type  = '0;
		pick_inode = '0;
		for (int e = 0; e < ENTRIES; e++) begin
			pick_name  = pick_name | cell_name[e];
			pick_type  = pick_type | cell_type[e];
			pick_inode = pick_inode | cell_inode[e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// hold the query for the length of the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q   <= wr_name;
			care_q    <= care_mask(wr_name);
			rd_mode_q <= (kind == KIND_READ);
			rd_idx_q  <= entry_index;
			last_q    <= POS_W'(act_cnt - CMP_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			raw_name_q  <= '0;
			raw_type_q  <= '0;
			raw_inode_q <= '0;
			done_q      <= 1'b0;
			status_q    <= STATUS_OK;
			found_q     <= '0;
			out_name_q  <= '0;
			out_type_q  <= '0;
			out_inode_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (start) begin
						out_name_q  <= '0;
						out_type_q  <= '0;
						out_inode_q <= '0;
						found_q     <= '0;
						if (launch) begin
							state_q <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
							case (kind)
								KIND_LOAD: begin
									if (idx_ext < ENT_C) begin
										status_q <= STATUS_OK;
										found_q  <= entry_index;
									end else begin
										status_q <= STATUS_RANGE;
									end
								end
								KIND_LOOKUP: status_q <= STATUS_MISS;
								default:     status_q <= STATUS_RANGE;
							endcase
						end
					end
				end
				ST_SCAN: begin
					if (any_sel) begin
						raw_name_q  <= pick_name;
						raw_type_q  <= pick_type;
						raw_inode_q <= pick_inode;
						found_q     <= IDX_W'(pos_q);
						state_q     <= ST_CUT;
					end else if (at_last) begin
						done_q   <= 1'b1;
						status_q <= rd_mode_q ? STATUS_RANGE : STATUS_MISS;
						state_q  <= ST_IDLE;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_CUT: begin
					// drop everything from the first zero byte on
					out_name_q  <= NAME_MAX_W'(raw_name_q & keep_mask(raw_name_q));
					out_type_q  <= raw_type_q;
					out_inode_q <= raw_inode_q;
					status_q    <= STATUS_OK;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign out_word0   = out_name_q[0*WORD_W +: WORD_W];
	assign out_word1   = out_name_q[1*WORD_W +: WORD_W];
	assign out_word2   = out_name_q[2*WORD_W +: WORD_W];
	assign out_word3   = out_name_q[3*WORD_W +: WORD_W];
	assign out_type    = out_type_q;
	assign out_inode   = out_inode_q;

	`DLK_ASSERT(a_tok_single, $onehot0(tok), "more than one scan token in the chain")
	`DLK_ASSERT(a_tok_in_scan, (state_q == ST_SCAN) |-> $onehot(tok[ENTRIES:1]),
		"scan running without exactly one token")
	`DLK_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result beat while busy")
	`DLK_ASSERT(a_accept_moves, accept |=> (done_q || busy), "accepted item produced nothing")
	`DLK_NEVER(a_tok_overrun, tok[ENTRIES] && !ctrl.flush, "scan token ran past the last cell")

endmodule

>>> hdl/dlk_cell.sv
// ----------------------------------------------------------------------------
// dlk_cell
// One directory entry: stores name, type and inode, compares against the
// broadcast query (or its index against the read index, in read mode) while
// it holds the scan token, and passes the token on.
module dlk_cell #(
	parameter int CELL_IDX   = 0,
	parameter int NAME_BYTES = dlk_pkg::DEF_NAME_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dlk_pkg::dlk_ctrl_t                ctrl,
	input  logic [NAME_BYTES*8-1:0]           wr_name,
	input  logic [dlk_pkg::TYPE_W-1:0]        wr_type,
	input  logic [dlk_pkg::INODE_W-1:0]       wr_inode,
	input  logic [NAME_BYTES*8-1:0]           query,
	input  logic [NAME_BYTES*8-1:0]           care,
	input  logic                              tok_in,
	output logic                              tok_out,
	output logic                              sel,
	output logic [NAME_BYTES*8-1:0]           sel_name,
	output logic [dlk_pkg::TYPE_W-1:0]        sel_type,
	output logic [dlk_pkg::INODE_W-1:0]       sel_inode
);
	import dlk_pkg::*;

	localparam int NAME_W = NAME_BYTES * 8;
	localparam bit ADDRESSABLE = CELL_IDX < (1 << IDX_W);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [NAME_W-1:0]  name_q;
	logic [TYPE_W-1:0]  type_q;
	logic [INODE_W-1:0] inode_q;
	logic               tok_q;
	logic               wr_hit;
	logic               rd_hit;
	logic               name_hit;

	assign wr_hit   = ADDRESSABLE && ctrl.wr_en && (ctrl.wr_idx == MY_IDX);
	assign rd_hit   = ADDRESSABLE && (ctrl.rd_idx == MY_IDX);
	// bytes up to and including the query terminator must agree
	assign name_hit = ((name_q ^ query) & care) == '0;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			name_q  <= wr_name;
			type_q  <= wr_type;
			inode_q <= wr_inode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= ctrl.flush ? 1'b0 : tok_in;
		end
	end

	assign tok_out   = tok_q;
	assign sel       = tok_q && (ctrl.rd_mode ? rd_hit : name_hit);
	assign sel_name  = sel ? name_q : '0;
	assign sel_type  = sel ? type_q : '0;
	assign sel_inode = sel ? inode_q : '0;

endmodule
